// ===== src/lbas_pkg.sv =====
package lbas_pkg;

   localparam int MAX_SEGMENTS = 28;
   localparam int FIRE_FRAMES  = 23;
   localparam int POS_W        = 7;
   localparam int DIV_NUM_W    = 21;
   localparam int DIV_DEN_W    = 10;
   localparam int DIV_CNT_W    = 5;

   // request kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // animation modes
   localparam logic [2:0] MODE_FILLDOWN = 3'd0;
   localparam logic [2:0] MODE_FILLUP   = 3'd1;
   localparam logic [2:0] MODE_FASTFILL = 3'd2;
   localparam logic [2:0] MODE_CYCLO    = 3'd3;
   localparam logic [2:0] MODE_CYCLOFUL = 3'd4;
   localparam logic [2:0] MODE_FIRE     = 3'd5;
   localparam logic [2:0] MODE_IDLE     = 3'd7;

   // phase flag bits
   localparam int PF_FILL_INIT  = 0;
   localparam int PF_FILL_DONE  = 1;
   localparam int PF_EMPTY_INIT = 2;
   localparam int PF_EMPTY_DONE = 3;

   // register indexes
   localparam logic REG_SEGMENT_COUNT = 1'b0;

   localparam logic [7:0] IV_RESET   = 8'd10;
   localparam logic [7:0] IV_FAST    = 8'd10;
   localparam logic [7:0] IV_CYCLO   = 8'd25;
   localparam logic [3:0] BRIGHT_MAX = 4'd15;
   localparam int CYCLO_TOP          = 14;

   // x / 100 for x below 2^15 as multiply and shift
   localparam int RECIP_100 = 5243;
   localparam int RECIP_SH  = 19;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_RSP  = 3'b100
   } state_type;

   function automatic logic [MAX_SEGMENTS-1:0] fire_frame(input logic [4:0] idx);
      logic [MAX_SEGMENTS-1:0] f;
      case (idx)
         5'd1:    f = 28'h0006000;
         5'd2:    f = 28'h000F000;
         5'd3:    f = 28'h001F800;
         5'd4:    f = 28'h003FC00;
         5'd5:    f = 28'h007FE00;
         5'd6:    f = 28'h00FFF00;
         5'd7:    f = 28'h01FFF80;
         5'd8:    f = 28'h03FFFC0;
         5'd9:    f = 28'h07F9FE0;
         5'd10:   f = 28'h0FF0FF0;
         5'd11:   f = 28'h1FE07F8;
         5'd12:   f = 28'h3FC03FC;
         5'd13:   f = 28'h7F801FE;
         5'd14:   f = 28'hFF000FF;
         5'd15:   f = 28'hFE0007F;
         5'd16:   f = 28'hFC0003F;
         5'd17:   f = 28'hF80001F;
         5'd18:   f = 28'hF00000F;
         5'd19:   f = 28'hE000007;
         5'd20:   f = 28'hC000003;
         5'd21:   f = 28'h8000001;
         default: f = 28'h0000000;
      endcase
      return f;
   endfunction

   // x / 100 via reciprocal, exact for x below 2^15
   function automatic logic [8:0] div100(input logic [14:0] x);
      logic [28:0] p;
      p = 29'(x) * 29'(RECIP_100);
      return 9'(p >> RECIP_SH);
   endfunction

endpackage

// ===== src/led_bar_animation_sequencer_unit.sv =====
// channel | dir | ports                  | contents
// req     | in  | req_t*                 | tuser: req_type; tdata: now/heat/mode/duration/flags
// rsp     | out | rsp_t*                 | tdata: led_states, brightness, refresh, done
// csr     | in  | csr_p*                 | segment_count at byte address 0
// A tick, clear or non-divide start is computed at accept and registered into the
// output register, where the word waits until taken. A start of fill-down, fill-up or
// fast-fill runs a restoring divider, one quotient bit per cycle, then registers the word.
// Reset is synchronous, active high; no input word is taken while a result is pending.
module led_bar_animation_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] now_ms, [38:32] heat_level, [41:39] anim_mode, [57:42] duration_ms,
   // [58] fade_enable, [59] burst_direction, [60] repeat_mode
   input  logic [63:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [27:0] led_states, [31:28] brightness, [32] refresh_needed, [33] sequence_done
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NS = lbas_pkg::MAX_SEGMENTS;
   localparam int PW = lbas_pkg::POS_W;

   lbas_pkg::state_type state_ff, state_in;
   logic [4:0]          seg_ff, seg_in;
   logic [NS-1:0]       led_ff, led_in;
   logic [3:0]          bright_ff, bright_in;
   logic signed [PW-1:0] pos_ff, pos_in;
   logic                down_ff, down_in;
   logic [31:0]         last_ff, last_in;
   logic [7:0]          iv_ff, iv_in;
   logic [2:0]          mode_ff, mode_in;
   logic [3:0]          pf_ff, pf_in;
   logic [1:0]          tog_ff, tog_in;
   logic [6:0]          lheat_ff, lheat_in;
   logic                chg_ff, chg_in;
   logic                fade_ff, fade_in;
   logic                rep_ff, rep_in;
   logic [lbas_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [lbas_pkg::DIV_DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [lbas_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [39:0]         out_ff, out_in;

   // input fields
   logic [31:0] now_ms;
   logic [6:0]  heat;
   logic [2:0]  amode;
   logic [15:0] dur;
   logic        fade_en, dir, rep;
   assign now_ms  = req_tdata[31:0];
   assign heat    = req_tdata[38:32];
   assign amode   = req_tdata[41:39];
   assign dur     = req_tdata[57:42];
   assign fade_en = req_tdata[58];
   assign dir     = req_tdata[59];
   assign rep     = req_tdata[60];

   // clamped segment count and output mask
   logic [4:0]    n;
   logic [NS-1:0] mask;
   always_comb begin
      if (seg_ff == 5'd0) n = 5'd1;
      else if (seg_ff > 5'(NS)) n = 5'(NS);
      else n = seg_ff;
      mask = NS'((29'(1) << n) - 29'(1));
   end

   // heat scaled floors and fire interval
   logic [4:0]  span;
   logic [8:0]  sc_cyc, sc_ful;
   logic [6:0]  hcl;
   logic [7:0]  fire_iv;
   logic [8:0]  fire_q;
   always_comb begin
      span    = (n > 5'd5) ? n - 5'd5 : 5'd0;
      sc_cyc  = lbas_pkg::div100(15'(12'(heat) * 12'(n)));
      if (sc_cyc > 9'(n)) sc_cyc = 9'(n);
      sc_ful  = lbas_pkg::div100(15'(12'(heat) * 12'(span)));
      if (sc_ful > 9'(span)) sc_ful = 9'(span);
      hcl     = (heat > 7'd100) ? 7'd100 : heat;
      fire_q  = lbas_pkg::div100(15'(15'(iv_ff - 8'd10) * 15'(hcl)));
      fire_iv = iv_ff - 8'(fire_q);
   end

   // step due check, one shared subtract and compare
   logic [7:0]  iv_sel;
   logic        is_due;
   always_comb begin
      if (mode_ff == lbas_pkg::MODE_FIRE) iv_sel = fire_iv;
      else if (mode_ff == lbas_pkg::MODE_FASTFILL && !pf_ff[lbas_pkg::PF_FILL_DONE])
         iv_sel = lbas_pkg::IV_FAST;
      else iv_sel = iv_ff;
      is_due = (now_ms - last_ff) >= 32'(iv_sel);
   end

   // divider trial subtract
   logic [lbas_pkg::DIV_DEN_W:0] trial;
   logic                         take;
   always_comb begin
      trial = {rem_ff, num_ff[lbas_pkg::DIV_NUM_W-1]};
      take  = trial >= {1'b0, den_ff};
   end

   // mode 0..2 divide operands
   logic [15:0] v01, v2;
   logic [8:0]  ten_n;
   always_comb begin
      v01   = (dur > 16'd5) ? dur : 16'd5;
      ten_n = 9'(n) * 9'd10;
      v2    = (dur > 16'(ten_n) + 16'd5) ? dur - 16'(ten_n) : 16'd5;
   end

   logic req_acc;
   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == lbas_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == lbas_pkg::ST_RSP);
   assign rsp_tdata  = out_ff;

   // main next-state logic
   always_comb begin
      logic signed [PW-1:0] ns_n;
      logic signed [PW-1:0] fl_cyc;
      logic signed [PW-1:0] sc_f;
      logic [NS-1:0] frow;
      logic ph_fup, ph_empty, ph_init, ph_go, ph_r;
      logic [4:0] fidx;
      state_in  = state_ff;
      led_in    = led_ff;
      bright_in = bright_ff;
      pos_in    = pos_ff;
      down_in   = down_ff;
      last_in   = last_ff;
      iv_in     = iv_ff;
      mode_in   = mode_ff;
      pf_in     = pf_ff;
      tog_in    = tog_ff;
      lheat_in  = lheat_ff;
      chg_in    = chg_ff;
      fade_in   = fade_ff;
      rep_in    = rep_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      out_in    = out_ff;
      ns_n      = PW'(n);
      fl_cyc    = PW'(sc_cyc[8:1]);
      sc_f      = PW'(sc_ful);
      frow      = '0;
      ph_fup    = 1'b0;
      ph_empty  = 1'b0;
      ph_init   = 1'b0;
      ph_go     = 1'b0;
      ph_r      = 1'b0;
      fidx      = 5'd0;

      unique case (state_ff)
         lbas_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = lbas_pkg::ST_RSP;
               case (req_tuser)
                  lbas_pkg::REQ_TICK: begin
                     case (mode_ff)
                        lbas_pkg::MODE_FILLDOWN, lbas_pkg::MODE_FILLUP,
                        lbas_pkg::MODE_FASTFILL: begin
                           // pick the phase to run
                           if (!pf_ff[lbas_pkg::PF_EMPTY_DONE]) begin
                              ph_go = 1'b1;
                              if (pf_ff[lbas_pkg::PF_FILL_INIT]) begin
                                 ph_init = 1'b1;
                                 ph_fup  = (mode_ff != lbas_pkg::MODE_FILLDOWN);
                              end else if (!pf_ff[lbas_pkg::PF_FILL_DONE]) begin
                                 ph_fup  = (mode_ff != lbas_pkg::MODE_FILLDOWN);
                              end else begin
                                 ph_empty = 1'b1;
                                 ph_init  = pf_ff[lbas_pkg::PF_EMPTY_INIT];
                              end
                           end
                           if (ph_go) begin
                              if (ph_init) begin
                                 pos_in = ph_fup ? '0 : ns_n;
                                 led_in = ph_empty ? '1 : '0;
                                 chg_in = 1'b1;
                              end
                              if (ph_fup) begin
                                 if (pos_in > ns_n) begin
                                    pos_in = ns_n;
                                    ph_r   = 1'b1;
                                 end else if (is_due) begin
                                    last_in = now_ms;
                                    chg_in  = 1'b1;
                                    if (pos_in >= 0 && pos_in < ns_n)
                                       led_in[pos_in[4:0]] = 1'b1;
                                    pos_in = pos_in + PW'(1);
                                 end
                              end else begin
                                 if (pos_in < 0) begin
                                    pos_in = '0;
                                    ph_r   = 1'b1;
                                 end else if (is_due) begin
                                    last_in = now_ms;
                                    chg_in  = 1'b1;
                                    if (pos_in < ns_n) led_in[pos_in[4:0]] = !ph_empty;
                                    pos_in = pos_in - PW'(1);
                                    if (fade_ff) begin
                                       if (!ph_empty) begin
                                          if (tog_ff[0] && bright_ff < lbas_pkg::BRIGHT_MAX)
                                             bright_in = bright_ff + 4'd1;
                                          tog_in[0] = !tog_ff[0];
                                       end else begin
                                          if (tog_ff[1] && bright_ff > 4'd0)
                                             bright_in = bright_ff - 4'd1;
                                          tog_in[1] = !tog_ff[1];
                                       end
                                    end
                                 end
                              end
                              // phase flag update
                              if (pf_ff[lbas_pkg::PF_FILL_INIT])
                                 pf_in[lbas_pkg::PF_FILL_INIT] = ph_r;
                              else if (!pf_ff[lbas_pkg::PF_FILL_DONE]) begin
                                 pf_in[lbas_pkg::PF_FILL_DONE]  = ph_r;
                                 pf_in[lbas_pkg::PF_EMPTY_INIT] = ph_r;
                              end else if (pf_ff[lbas_pkg::PF_EMPTY_INIT])
                                 pf_in[lbas_pkg::PF_EMPTY_INIT] = ph_r;
                              else
                                 pf_in[lbas_pkg::PF_EMPTY_DONE] = ph_r;
                           end
                        end
                        lbas_pkg::MODE_CYCLO: begin
                           if (is_due) begin
                              last_in = now_ms;
                              chg_in  = 1'b1;
                              for (int i = 0; i < NS; i++) begin
                                 if (PW'(i) < ns_n)
                                    led_in[i] = (PW'(i) < pos_ff) || (PW'(i) >= ns_n - pos_ff);
                              end
                              if (!down_ff) begin
                                 pos_in = (pos_ff + PW'(1) < PW'(lbas_pkg::CYCLO_TOP)) ?
                                          pos_ff + PW'(1) : PW'(lbas_pkg::CYCLO_TOP);
                                 if (pos_in >= PW'(lbas_pkg::CYCLO_TOP)) down_in = 1'b1;
                              end else begin
                                 pos_in = (pos_ff - PW'(1) > fl_cyc) ?
                                          pos_ff - PW'(1) : fl_cyc;
                                 if (pos_in <= fl_cyc) down_in = 1'b0;
                              end
                           end
                        end
                        lbas_pkg::MODE_CYCLOFUL: begin
                           if (is_due) begin
                              if (lheat_ff != heat) begin
                                 lheat_in = heat;
                                 chg_in   = 1'b1;
                              end
                              if (!down_ff) begin
                                 if (pos_ff >= ns_n) begin
                                    pos_in  = ns_n - PW'(1);
                                    down_in = 1'b1;
                                 end else begin
                                    last_in = now_ms;
                                    chg_in  = 1'b1;
                                    if (pos_ff >= 0) led_in[pos_ff[4:0]] = 1'b1;
                                    pos_in = pos_ff + PW'(1);
                                 end
                              end else begin
                                 if (pos_ff <= sc_f) begin
                                    pos_in  = sc_f;
                                    down_in = 1'b0;
                                 end else begin
                                    last_in = now_ms;
                                    chg_in  = 1'b1;
                                    if (pos_ff < PW'(NS)) led_in[pos_ff[4:0]] = 1'b0;
                                    pos_in = pos_ff - PW'(1);
                                 end
                              end
                           end
                        end
                        lbas_pkg::MODE_FIRE: begin
                           if (is_due) begin
                              if (pos_ff < 0) pos_in = '0;
                              else if (pos_ff > PW'(lbas_pkg::FIRE_FRAMES - 1))
                                 pos_in = PW'(lbas_pkg::FIRE_FRAMES - 1);
                              else pos_in = pos_ff;
                              last_in = now_ms;
                              chg_in  = 1'b1;
                              fidx    = pos_in[4:0];
                              frow    = lbas_pkg::fire_frame(fidx);
                              for (int i = 0; i < NS; i++) begin
                                 if (PW'(i) < ns_n) led_in[i] = frow[i];
                              end
                              if (!down_ff) begin
                                 pos_in = pos_in - PW'(1);
                                 if (pos_in < 0)
                                    pos_in = rep_ff ? PW'(lbas_pkg::FIRE_FRAMES - 1) : '0;
                              end else begin
                                 pos_in = pos_in + PW'(1);
                                 if (pos_in > PW'(lbas_pkg::FIRE_FRAMES - 1))
                                    pos_in = rep_ff ? '0 : PW'(lbas_pkg::FIRE_FRAMES - 1);
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
                  lbas_pkg::REQ_START: begin
                     case (amode)
                        lbas_pkg::MODE_FILLDOWN, lbas_pkg::MODE_FILLUP: begin
                           fade_in   = (amode == lbas_pkg::MODE_FILLDOWN) && fade_en;
                           bright_in = ((amode == lbas_pkg::MODE_FILLDOWN) && fade_en) ?
                                       4'd0 : lbas_pkg::BRIGHT_MAX;
                           pf_in     = 4'b0001 |
                                       ((amode == lbas_pkg::MODE_FILLUP) ? 4'b0100 : 4'b0000);
                           mode_in   = amode;
                           num_in    = lbas_pkg::DIV_NUM_W'(v01);
                           den_in    = lbas_pkg::DIV_DEN_W'({n, 1'b0});
                           rem_in    = '0;
                           cnt_in    = '0;
                           state_in  = lbas_pkg::ST_DIV;
                        end
                        lbas_pkg::MODE_FASTFILL: begin
                           fade_in   = fade_en;
                           bright_in = lbas_pkg::BRIGHT_MAX;
                           pf_in     = 4'b0101;
                           mode_in   = amode;
                           num_in    = lbas_pkg::DIV_NUM_W'(21'(v2) * 21'd20 + 21'(n) * 21'd11);
                           den_in    = lbas_pkg::DIV_DEN_W'(10'(n) * 10'd22);
                           rem_in    = '0;
                           cnt_in    = '0;
                           state_in  = lbas_pkg::ST_DIV;
                        end
                        lbas_pkg::MODE_CYCLO: begin
                           iv_in     = lbas_pkg::IV_CYCLO;
                           down_in   = 1'b0;
                           pos_in    = PW'(sc_cyc);
                           bright_in = lbas_pkg::BRIGHT_MAX;
                           led_in    = '0;
                           chg_in    = 1'b1;
                           mode_in   = amode;
                        end
                        lbas_pkg::MODE_CYCLOFUL: begin
                           iv_in     = lbas_pkg::IV_RESET;
                           lheat_in  = '0;
                           down_in   = 1'b0;
                           pos_in    = '0;
                           bright_in = lbas_pkg::BRIGHT_MAX;
                           led_in    = '0;
                           chg_in    = 1'b1;
                           mode_in   = amode;
                        end
                        lbas_pkg::MODE_FIRE: begin
                           down_in = dir;
                           rep_in  = rep;
                           if (rep) begin
                              iv_in     = lbas_pkg::IV_CYCLO;
                              pos_in    = dir ? '0 : PW'(lbas_pkg::FIRE_FRAMES - 1);
                              bright_in = lbas_pkg::BRIGHT_MAX;
                              led_in    = '0;
                              chg_in    = 1'b1;
                           end
                           mode_in = amode;
                        end
                        default: ;
                     endcase
                  end
                  lbas_pkg::REQ_CLEAR: begin
                     pos_in    = '0;
                     bright_in = lbas_pkg::BRIGHT_MAX;
                     led_in    = '0;
                     chg_in    = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         lbas_pkg::ST_DIV: begin
            // one quotient bit per cycle
            rem_in = take ? lbas_pkg::DIV_DEN_W'(trial - {1'b0, den_ff})
                          : lbas_pkg::DIV_DEN_W'(trial);
            num_in = {num_ff[lbas_pkg::DIV_NUM_W-2:0], take};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lbas_pkg::DIV_CNT_W'(lbas_pkg::DIV_NUM_W - 1)) begin
               if (num_in < 21'd10) iv_in = 8'd10;
               else if (num_in > 21'd255) iv_in = 8'd255;
               else iv_in = num_in[7:0];
               state_in = lbas_pkg::ST_RSP;
            end
         end
         lbas_pkg::ST_RSP: begin
            if (rsp_tready) state_in = lbas_pkg::ST_IDLE;
         end
         default: state_in = lbas_pkg::ST_IDLE;
      endcase

      // capture result word when leaving compute
      if (state_in == lbas_pkg::ST_RSP && state_ff != lbas_pkg::ST_RSP) begin
         out_in = {6'd0,
                   (mode_in <= lbas_pkg::MODE_FASTFILL) && pf_in[lbas_pkg::PF_EMPTY_DONE],
                   chg_in, bright_in, led_in & mask};
         chg_in = 1'b0;
      end
   end

   // config port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == lbas_pkg::REG_SEGMENT_COUNT) ? {27'd0, seg_ff} : 32'd0;
   always_comb begin
      seg_in = seg_ff;
      if (csr_wr && csr_paddr[2] == lbas_pkg::REG_SEGMENT_COUNT) seg_in = csr_pwdata[4:0];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lbas_pkg::ST_IDLE;
         seg_ff    <= 5'd28;
         led_ff    <= '0;
         bright_ff <= lbas_pkg::BRIGHT_MAX;
         pos_ff    <= '0;
         down_ff   <= 1'b0;
         last_ff   <= '0;
         iv_ff     <= lbas_pkg::IV_RESET;
         mode_ff   <= lbas_pkg::MODE_IDLE;
         pf_ff     <= '0;
         tog_ff    <= '0;
         lheat_ff  <= '0;
         chg_ff    <= 1'b1;
         fade_ff   <= 1'b0;
         rep_ff    <= 1'b1;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         seg_ff    <= seg_in;
         led_ff    <= led_in;
         bright_ff <= bright_in;
         pos_ff    <= pos_in;
         down_ff   <= down_in;
         last_ff   <= last_in;
         iv_ff     <= iv_in;
         mode_ff   <= mode_in;
         pf_ff     <= pf_in;
         tog_ff    <= tog_in;
         lheat_ff  <= lheat_in;
         chg_ff    <= chg_in;
         fade_ff   <= fade_in;
         rep_ff    <= rep_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      out_ff <= out_in;
   end

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == lbas_pkg::REQ_START &&
       (req_tdata[41:39] == lbas_pkg::MODE_FILLDOWN || req_tdata[41:39] == lbas_pkg::MODE_FILLUP ||
        req_tdata[41:39] == lbas_pkg::MODE_FASTFILL)) |=> !rsp_tvalid && !req_tready)
      else $error("divider not started");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbas_pkg::ST_DIV) |-> cnt_ff < lbas_pkg::DIV_CNT_W'(lbas_pkg::DIV_NUM_W))
      else $error("divider overran");
`endif

endmodule
